// ===== src/gbn_pkg.sv =====
`timescale 1ns / 1ps

package gbn_pkg;

  localparam int MAX_WINDOW    = 8;
  localparam int SEQ_WIDTH     = 8;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int MOD_W   = SEQ_WIDTH + 1;
  localparam int MOD_TOP = 1 << SEQ_WIDTH;
  localparam int RC_W    = $clog2(SEQ_WIDTH + 1);

  // Configuration register fields.
  localparam int WINCFG_W = 4;
  localparam int MODCFG_W = 9;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic REG_WINDOW  = 1'b0;
  localparam logic REG_MODULUS = 1'b1;

  localparam logic [WINCFG_W-1:0] WINDOW_RESET  = WINCFG_W'(4);
  localparam logic [MODCFG_W-1:0] MODULUS_RESET = MODCFG_W'(8);

  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  localparam logic [2:0] ST_REFUSED     = 3'd0;
  localparam logic [2:0] ST_SENT        = 3'd1;
  localparam logic [2:0] ST_RESENT      = 3'd2;
  localparam logic [2:0] ST_ACK_OK      = 3'd3;
  localparam logic [2:0] ST_ACK_CORRUPT = 3'd4;
  localparam logic [2:0] ST_ACK_OUTSIDE = 3'd5;
  localparam logic [2:0] ST_TO_EMPTY    = 3'd6;

  typedef struct packed {
    logic [1:0]               op;
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic [SEQ_WIDTH-1:0]     ack_num;
    logic                     ack_checksum_ok;
    logic [SEQ_WIDTH-1:0]     expired_seq;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [SEQ_WIDTH-1:0]     pkt_seq;
    logic [PAYLOAD_WIDTH-1:0] pkt_payload;
    logic                     timer_stop;
    logic [SEQ_WIDTH-1:0]     timer_stop_seq;
    logic                     timer_start;
    logic [SEQ_WIDTH-1:0]     timer_start_seq;
    logic [CNT_W-1:0]         window_fill;
    logic [SEQ_WIDTH-1:0]     base_seq;
    logic                     last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic ack_step;
    logic exec;
    logic replay;
  } gbn_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       rem_busy;
    logic [1:0] op;
    logic       has_pkts;
    logic       replay_last;
  } gbn_sts_t;

endpackage

// ===== src/gbn_ram.sv =====
`timescale 1ns / 1ps

module gbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== src/gbn_ctrl.sv =====
`timescale 1ns / 1ps

module gbn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_op,
  input  gbn_pkg::gbn_sts_t sts,
  output gbn_pkg::gbn_cmd_t cmd,
  output logic              busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACK,
    S_EXEC,
    S_REPLAY
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_op == gbn_pkg::OP_ACK) ? S_ACK : S_EXEC;
        end
      end
      // The ack number has been reduced; now reduce the base.
      S_ACK: begin
        if (!sts.rem_busy) begin
          cmd.ack_step = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.rem_busy) begin
          cmd.exec = 1'b1;
          if (sts.op == gbn_pkg::OP_TIMEOUT && sts.has_pkts) begin
            state_nxt = S_REPLAY;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_REPLAY: begin
        cmd.replay = 1'b1;
        if (sts.replay_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ===== src/gbn_dp.sv =====
`timescale 1ns / 1ps

module gbn_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gbn_pkg::gbn_cmd_t                 cmd,
  output gbn_pkg::gbn_sts_t                 sts,
  input  gbn_pkg::in_item_t                 in_item,
  output gbn_pkg::out_item_t                out_item,
  output logic                              out_strobe,
  input  logic                              cfg_wr,
  input  logic [gbn_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [gbn_pkg::CFG_DW-1:0]        cfg_wdata,
  output logic [gbn_pkg::CFG_DW-1:0]        cfg_rdata
);

  localparam int SW = gbn_pkg::SEQ_WIDTH;
  localparam int MW = gbn_pkg::MOD_W;
  localparam int CW = gbn_pkg::CNT_W;
  localparam int IW = gbn_pkg::IDX_W;
  localparam int PW = gbn_pkg::PAYLOAD_WIDTH;

  // Configuration registers.
  logic [gbn_pkg::WINCFG_W-1:0] win_cfg_r;
  logic [gbn_pkg::MODCFG_W-1:0] mod_cfg_r;
  logic [MW-1:0]                mod_eff;
  logic [CW-1:0]                win_eff;
  int                           win_tmp;

  // Protocol state.
  logic [SW-1:0] base_r, base_nxt;
  logic [SW-1:0] next_r, next_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] head_r, head_nxt;

  // Latched item.
  logic [1:0]    op_r;
  logic [PW-1:0] pay_r;
  logic          chk_r;
  logic [SW-1:0] es_r;
  logic [SW-1:0] ack_m_r;

  // Remainder unit: one quotient bit per cycle, skipped when already in range.
  logic [SW-1:0]             rem_r, rem_nxt;
  logic [SW-1:0]             src_r, src_nxt;
  logic [gbn_pkg::RC_W-1:0]  rcnt_r, rcnt_nxt;
  logic                      rem_load;
  logic [SW-1:0]             rem_opnd;
  logic [MW-1:0]             rem_t;

  // Replay.
  logic [IW-1:0] ridx_r, ridx_nxt, ridx_inc;
  logic [IW-1:0] rep_i_r, rep_i_nxt;
  logic [SW-1:0] rseq_r, rseq_nxt, rseq_inc;

  // Output register.
  gbn_pkg::out_item_t out_r, out_nxt;
  logic               strobe_r, strobe_nxt;

  // Memory port.
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [PW-1:0] ram_rdata;

  // Work values.
  logic [CW:0]   wsum, hsum;
  logic [MW-1:0] seq_inc, off;
  logic [MW:0]   nb_sum;
  logic [SW-1:0] nb;
  logic          more;

  always_comb begin
    if (int'(mod_cfg_r) < 2) begin
      mod_eff = MW'(2);
    end else if (int'(mod_cfg_r) > gbn_pkg::MOD_TOP) begin
      mod_eff = MW'(gbn_pkg::MOD_TOP);
    end else begin
      mod_eff = MW'(mod_cfg_r);
    end
    win_tmp = int'(win_cfg_r);
    if (win_tmp < 1) begin
      win_tmp = 1;
    end
    if (win_tmp > gbn_pkg::MAX_WINDOW) begin
      win_tmp = gbn_pkg::MAX_WINDOW;
    end
    if (win_tmp > int'(mod_eff) - 1) begin
      win_tmp = int'(mod_eff) - 1;
    end
    win_eff = CW'(win_tmp);
  end

  always_comb begin
    cfg_rdata = '0;
    if (cfg_addr[2] == gbn_pkg::REG_WINDOW) begin
      cfg_rdata = gbn_pkg::CFG_DW'(win_cfg_r);
    end else begin
      cfg_rdata = gbn_pkg::CFG_DW'(mod_cfg_r);
    end
  end

  // Remainder unit.
  always_comb begin
    rem_load = cmd.accept | cmd.ack_step;
    rem_opnd = base_r;
    if (cmd.accept) begin
      unique case (in_item.op)
        gbn_pkg::OP_SEND: rem_opnd = next_r;
        gbn_pkg::OP_ACK:  rem_opnd = in_item.ack_num;
        default:          rem_opnd = base_r;
      endcase
    end
    rem_t    = {rem_r, src_r[SW-1]};
    rem_nxt  = rem_r;
    src_nxt  = src_r;
    rcnt_nxt = rcnt_r;
    if (rem_load) begin
      if (MW'(rem_opnd) < mod_eff) begin
        rem_nxt  = rem_opnd;
        rcnt_nxt = '0;
      end else begin
        rem_nxt  = '0;
        src_nxt  = rem_opnd;
        rcnt_nxt = gbn_pkg::RC_W'(SW);
      end
    end else if (rcnt_r != '0) begin
      rem_nxt  = (rem_t >= mod_eff) ? SW'(rem_t - mod_eff) : SW'(rem_t);
      src_nxt  = src_r << 1;
      rcnt_nxt = rcnt_r - 1'b1;
    end
  end

  // Main step logic.
  always_comb begin
    base_nxt   = base_r;
    next_nxt   = next_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    ridx_nxt   = ridx_r;
    rep_i_nxt  = rep_i_r;
    rseq_nxt   = rseq_r;
    strobe_nxt = 1'b0;
    out_nxt    = '0;
    ram_we     = 1'b0;

    wsum = (CW+1)'(head_r) + (CW+1)'(count_r);
    if (int'(wsum) >= gbn_pkg::MAX_WINDOW) begin
      wsum = wsum - (CW+1)'(gbn_pkg::MAX_WINDOW);
    end
    ram_waddr = IW'(wsum);

    seq_inc = MW'(rem_r) + MW'(1);
    if (seq_inc == mod_eff) begin
      seq_inc = '0;
    end

    if (MW'(ack_m_r) >= MW'(rem_r)) begin
      off = MW'(ack_m_r) - MW'(rem_r);
    end else begin
      off = MW'(ack_m_r) + mod_eff - MW'(rem_r);
    end
    nb_sum = (MW+1)'(rem_r) + (MW+1)'(off) + (MW+1)'(1);
    if (nb_sum >= (MW+1)'(mod_eff)) begin
      nb_sum = nb_sum - (MW+1)'(mod_eff);
    end
    nb   = SW'(nb_sum);
    hsum = (CW+1)'(head_r) + (CW+1)'(CW'(off)) + (CW+1)'(1);
    if (int'(hsum) >= gbn_pkg::MAX_WINDOW) begin
      hsum = hsum - (CW+1)'(gbn_pkg::MAX_WINDOW);
    end
    more = (count_r != CW'(off) + CW'(1));

    ridx_inc = (ridx_r == IW'(gbn_pkg::MAX_WINDOW - 1)) ? '0 : ridx_r + 1'b1;
    // The replayed sequence number steps and wraps on its own, since the fill
    // may exceed a modulus that was lowered while packets were outstanding.
    rseq_inc = (MW'(rseq_r) + MW'(1) == mod_eff) ? '0 : rseq_r + 1'b1;
    ram_raddr = cmd.replay ? ridx_inc : head_r;

    out_nxt.last = 1'b1;

    if (cmd.exec) begin
      unique case (op_r)
        gbn_pkg::OP_SEND: begin
          strobe_nxt = 1'b1;
          if (count_r >= win_eff) begin
            out_nxt.status = gbn_pkg::ST_REFUSED;
          end else begin
            ram_we                  = 1'b1;
            count_nxt               = count_r + 1'b1;
            next_nxt                = SW'(seq_inc);
            out_nxt.status          = gbn_pkg::ST_SENT;
            out_nxt.pkt_seq         = rem_r;
            out_nxt.pkt_payload     = pay_r;
            out_nxt.timer_start     = (count_r == '0);
            out_nxt.timer_start_seq = (count_r == '0) ? rem_r : '0;
          end
        end
        gbn_pkg::OP_ACK: begin
          strobe_nxt = 1'b1;
          if (!chk_r) begin
            out_nxt.status = gbn_pkg::ST_ACK_CORRUPT;
          end else if (int'(off) >= int'(count_r)) begin
            out_nxt.status = gbn_pkg::ST_ACK_OUTSIDE;
          end else begin
            count_nxt               = count_r - CW'(off) - CW'(1);
            head_nxt                = IW'(hsum);
            base_nxt                = nb;
            out_nxt.status          = gbn_pkg::ST_ACK_OK;
            out_nxt.timer_stop      = 1'b1;
            out_nxt.timer_stop_seq  = rem_r;
            out_nxt.timer_start     = more;
            out_nxt.timer_start_seq = more ? nb : '0;
          end
        end
        gbn_pkg::OP_TIMEOUT: begin
          if (count_r == '0) begin
            strobe_nxt              = 1'b1;
            out_nxt.status          = gbn_pkg::ST_TO_EMPTY;
            out_nxt.timer_stop      = 1'b1;
            out_nxt.timer_stop_seq  = es_r;
            out_nxt.timer_start     = 1'b1;
            out_nxt.timer_start_seq = es_r;
          end else begin
            // The oldest entry is read now; results follow one per cycle.
            ridx_nxt  = head_r;
            rep_i_nxt = '0;
            rseq_nxt  = rem_r;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.replay) begin
      strobe_nxt              = 1'b1;
      out_nxt.status          = gbn_pkg::ST_RESENT;
      out_nxt.pkt_seq         = rseq_r;
      out_nxt.pkt_payload     = ram_rdata;
      out_nxt.timer_stop      = (rep_i_r == '0);
      out_nxt.timer_stop_seq  = (rep_i_r == '0) ? es_r : '0;
      out_nxt.timer_start     = (rep_i_r == '0);
      out_nxt.timer_start_seq = (rep_i_r == '0) ? es_r : '0;
      out_nxt.last            = (CW'(rep_i_r) + CW'(1) == count_r);
      ridx_nxt                = ridx_inc;
      rep_i_nxt               = rep_i_r + 1'b1;
      rseq_nxt                = rseq_inc;
    end

    out_nxt.window_fill = count_nxt;
    out_nxt.base_seq    = base_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r <= gbn_pkg::WINDOW_RESET;
      mod_cfg_r <= gbn_pkg::MODULUS_RESET;
      base_r    <= '0;
      next_r    <= '0;
      count_r   <= '0;
      head_r    <= '0;
      rcnt_r    <= '0;
      strobe_r  <= 1'b0;
      op_r      <= gbn_pkg::OP_SEND;
    end else begin
      if (cfg_wr) begin
        if (cfg_addr[2] == gbn_pkg::REG_WINDOW) begin
          win_cfg_r <= cfg_wdata[gbn_pkg::WINCFG_W-1:0];
        end else begin
          mod_cfg_r <= cfg_wdata[gbn_pkg::MODCFG_W-1:0];
        end
      end
      base_r   <= base_nxt;
      next_r   <= next_nxt;
      count_r  <= count_nxt;
      head_r   <= head_nxt;
      rcnt_r   <= rcnt_nxt;
      strobe_r <= strobe_nxt;
      if (cmd.accept) begin
        op_r <= in_item.op;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pay_r <= in_item.payload;
      chk_r <= in_item.ack_checksum_ok;
      es_r  <= in_item.expired_seq;
    end
    if (cmd.ack_step) begin
      ack_m_r <= rem_r;
    end
    rem_r   <= rem_nxt;
    src_r   <= src_nxt;
    ridx_r  <= ridx_nxt;
    rep_i_r <= rep_i_nxt;
    rseq_r  <= rseq_nxt;
    out_r   <= out_nxt;
  end

  gbn_ram #(
    .WIDTH(PW),
    .DEPTH(gbn_pkg::MAX_WINDOW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(pay_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign sts.rem_busy    = (rcnt_r != '0);
  assign sts.op          = op_r;
  assign sts.has_pkts    = (count_r != '0);
  assign sts.replay_last = (CW'(rep_i_r) + CW'(1) == count_r);

  assign out_item   = out_r;
  assign out_strobe = strobe_r;

endmodule

// ===== src/go_back_n_sender_window.sv =====
`timescale 1ns / 1ps

// Go-Back-N sender window. An operation is taken when start is high and busy is
// low; each result appears for exactly one cycle with out_strobe high and must be
// captured then, since the receiver cannot stall the block. An op 3 produces no
// result. An acknowledgement first reduces the ack number and then the base. A
// timeout with packets outstanding replays the stored payloads one per cycle
// through the single read port of the window memory. A sequence or ack number at
// or above the current modulus first goes through the bit-serial remainder unit.
module go_back_n_sender_window (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  gbn_pkg::in_item_t            in_item,
  output gbn_pkg::out_item_t           out_item,
  output logic                         out_strobe,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gbn_pkg::CFG_AW-1:0]   paddr,
  input  logic [gbn_pkg::CFG_DW-1:0]   pwdata,
  output logic [gbn_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);

  gbn_pkg::gbn_cmd_t cmd;
  gbn_pkg::gbn_sts_t sts;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  gbn_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .in_op(in_item.op),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  gbn_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_strobe(out_strobe),
    .cfg_wr    (cfg_wr),
    .cfg_addr  (paddr),
    .cfg_wdata (pwdata),
    .cfg_rdata (prdata)
  );

endmodule

// ===== src/gbn_chk.sv =====
`timescale 1ns / 1ps

module gbn_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input gbn_pkg::in_item_t            in_item,
  input gbn_pkg::out_item_t           out_item,
  input logic                         out_strobe,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [gbn_pkg::CFG_AW-1:0]   paddr,
  input logic [gbn_pkg::CFG_DW-1:0]   pwdata,
  input logic [gbn_pkg::CFG_DW-1:0]   prdata,
  input logic                         pready
);

  // An accepted transfer always raises busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted transfer");

  // A replay burst delivers its results in consecutive cycles.
  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last) |=> out_strobe)
    else $error("gap inside a multi-result burst");

  // The result after a final one cannot come in the very next cycle.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last) |=> !out_strobe)
    else $error("result directly after a final result");

  // Once the block is idle only the final result of a transfer may still show.
  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && out_strobe) |-> out_item.last)
    else $error("non-final result while idle");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (int'(out_item.window_fill) <= gbn_pkg::MAX_WINDOW))
    else $error("window fill above the maximum window");

endmodule

bind go_back_n_sender_window gbn_chk u_chk (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import gbn_pkg::*;

  // The block ignores this op code and produces no result for it.
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam logic [CFG_AW-1:0] WINDOW_ADDR  = {REG_WINDOW, 2'b00};
  localparam logic [CFG_AW-1:0] MODULUS_ADDR = {REG_MODULUS, 2'b00};

  // Ring of expected reports; far deeper than the results ever pending.
  localparam int REPORT_DEPTH = 64;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  in_item_t          tx_cmd  = '0;
  out_item_t         tx_report;
  logic              tx_strobe;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [CFG_DW-1:0] pwdata  = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Shadow of the sender state and its registers.
  logic [WINCFG_W-1:0]      win_cfg = WINDOW_RESET;
  logic [MODCFG_W-1:0]      mod_cfg = MODULUS_RESET;
  logic [PAYLOAD_WIDTH-1:0] unacked_payloads [MAX_WINDOW];
  int                       base_num = 0;
  int                       next_seq = 0;
  int                       fill     = 0;
  int                       head     = 0;

  out_item_t sender_reports [REPORT_DEPTH];
  int        report_wr   = 0;
  int        report_rd   = 0;
  int        error_count = 0;
  bit        idle_on     = 1'b1;

  go_back_n_sender_window uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (tx_cmd),
    .out_item  (tx_report),
    .out_strobe(tx_strobe),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task automatic expect_report(input out_item_t r);
    sender_reports[report_wr % REPORT_DEPTH] = r;
    report_wr++;
  endtask

  function automatic int seq_span();
    int m;
    m = mod_cfg;
    if (m < 2) m = 2;
    if (m > MOD_TOP) m = MOD_TOP;
    return m;
  endfunction

  function automatic int window_limit(input int m);
    int w;
    w = win_cfg;
    if (w < 1) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    if (w > m - 1) w = m - 1;
    return w;
  endfunction

  function automatic out_item_t blank_report();
    out_item_t r;
    r = '0;
    r.window_fill = CNT_W'(fill);
    r.base_seq = SEQ_WIDTH'(base_num);
    r.last = 1'b1;
    return r;
  endfunction

  // Advances the shadow state by one accepted command and queues the reports.
  task automatic step_sender(input in_item_t item);
    int m, w, seq, ackv, b, off, n;
    out_item_t r;
    m = seq_span();
    w = window_limit(m);
    case (item.op)
      OP_SEND: begin
        if (fill >= w) begin
          r = blank_report();
          r.status = ST_REFUSED;
        end else begin
          seq = next_seq % m;
          unacked_payloads[(head + fill) % MAX_WINDOW] = item.payload;
          fill++;
          next_seq = (seq + 1) % m;
          r = blank_report();
          r.status = ST_SENT;
          r.pkt_seq = SEQ_WIDTH'(seq);
          r.pkt_payload = item.payload;
          if (fill == 1) begin
            r.timer_start = 1'b1;
            r.timer_start_seq = SEQ_WIDTH'(seq);
          end
        end
        expect_report(r);
      end
      OP_ACK: begin
        ackv = int'(item.ack_num) % m;
        b = base_num % m;
        off = (ackv + m - b) % m;
        if (!item.ack_checksum_ok) begin
          r = blank_report();
          r.status = ST_ACK_CORRUPT;
        end else if (off >= fill) begin
          r = blank_report();
          r.status = ST_ACK_OUTSIDE;
        end else begin
          fill -= off + 1;
          head = (head + off + 1) % MAX_WINDOW;
          base_num = (b + off + 1) % m;
          r = blank_report();
          r.status = ST_ACK_OK;
          r.timer_stop = 1'b1;
          r.timer_stop_seq = SEQ_WIDTH'(b);
          if (fill != 0) begin
            r.timer_start = 1'b1;
            r.timer_start_seq = SEQ_WIDTH'(base_num);
          end
        end
        expect_report(r);
      end
      OP_TIMEOUT: begin
        n = fill;
        if (n == 0) begin
          r = blank_report();
          r.status = ST_TO_EMPTY;
          r.timer_stop = 1'b1;
          r.timer_stop_seq = item.expired_seq;
          r.timer_start = 1'b1;
          r.timer_start_seq = item.expired_seq;
          expect_report(r);
        end else begin
          // Every outstanding packet is replayed oldest first; only the first
          // result carries the timer restart.
          for (int i = 0; i < n; i++) begin
            r = blank_report();
            r.status = ST_RESENT;
            r.pkt_seq = SEQ_WIDTH'((base_num % m + i) % m);
            r.pkt_payload = unacked_payloads[(head + i) % MAX_WINDOW];
            r.last = (i == n - 1);
            if (i == 0) begin
              r.timer_stop = 1'b1;
              r.timer_stop_seq = item.expired_seq;
              r.timer_start = 1'b1;
              r.timer_start_seq = item.expired_seq;
            end
            expect_report(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t make_command(input logic [1:0] op,
                                            input logic [PAYLOAD_WIDTH-1:0] payload,
                                            input logic [SEQ_WIDTH-1:0] ack_num,
                                            input logic ok,
                                            input logic [SEQ_WIDTH-1:0] expired);
    in_item_t item;
    item.op = op;
    item.payload = payload;
    item.ack_num = ack_num;
    item.ack_checksum_ok = ok;
    item.expired_seq = expired;
    return item;
  endfunction

  // Mostly sends and acks that land inside or just past the window, so the
  // window fills, slides and wraps; the rest is timeouts, stray acks and op 3.
  function automatic in_item_t random_command();
    in_item_t item;
    int pick, m;
    m = seq_span();
    item.payload = $urandom;
    item.ack_num = SEQ_WIDTH'($urandom_range(0, 255));
    item.ack_checksum_ok = ($urandom_range(0, 99) < 85);
    item.expired_seq = SEQ_WIDTH'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      item.op = OP_SEND;
    end else if (pick < 78) begin
      item.op = OP_ACK;
      if ($urandom_range(0, 9) < 8)
        item.ack_num = SEQ_WIDTH'((base_num % m + $urandom_range(0, fill)) % m);
    end else if (pick < 96) begin
      item.op = OP_TIMEOUT;
    end else begin
      item.op = OP_IGNORED;
    end
    return item;
  endfunction

  task automatic send_command(input in_item_t item);
    if (idle_on && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    tx_cmd <= item;
    do @(posedge clk); while (busy);
    step_sender(item);
  endtask

  // Waits until every report has arrived and the block has gone quiet; an op 3
  // or a remainder pass may still be running after the last report.
  task automatic settle_block();
    start <= 1'b0;
    while (report_wr != report_rd) @(posedge clk);
    repeat (40) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Writes one register, reads it back and updates the shadow copy.
  task automatic program_register(input logic [CFG_AW-1:0] addr,
                                  input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] want;
    logic [CFG_DW-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == WINDOW_ADDR) begin
      win_cfg = value[WINCFG_W-1:0];
      want = CFG_DW'(win_cfg);
    end else begin
      mod_cfg = value[MODCFG_W-1:0];
      want = CFG_DW'(mod_cfg);
    end
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      report_mismatch($sformatf("register at %0d reads %h, wrote %h", addr, got, want));
  endtask

  task automatic test_directed_cases();
    // Reset settings: window 4, modulus 8.
    send_command(make_command(OP_TIMEOUT, '0, '0, 1'b1, 8'd0));
    send_command(make_command(OP_TIMEOUT, '1, '1, 1'b0, 8'd255));
    send_command(make_command(OP_ACK, '0, 8'd0, 1'b0, '0));
    send_command(make_command(OP_ACK, '0, 8'd0, 1'b1, '0));
    send_command(make_command(OP_IGNORED, 32'hDEADBEEF, 8'hFF, 1'b1, 8'hFF));
    send_command(make_command(OP_SEND, 32'h0000_0000, '0, 1'b0, '0));
    send_command(make_command(OP_SEND, 32'hFFFF_FFFF, '1, 1'b1, '1));
    send_command(make_command(OP_SEND, 32'hA5A5_A5A5, '0, 1'b0, '0));
    send_command(make_command(OP_SEND, 32'h5A5A_5A5A, '0, 1'b0, '0));
    send_command(make_command(OP_SEND, 32'h1234_5678, '0, 1'b1, '0));
    send_command(make_command(OP_TIMEOUT, '0, '0, 1'b0, 8'd3));
    send_command(make_command(OP_ACK, '0, 8'd1, 1'b0, '0));
    // An ack number at or above the modulus wraps: 9 acknowledges seq 1.
    send_command(make_command(OP_ACK, '0, 8'd9, 1'b1, '0));
    send_command(make_command(OP_ACK, '0, 8'd255, 1'b1, '0));
    send_command(make_command(OP_ACK, '0, 8'd3, 1'b1, '0));
    send_command(make_command(OP_SEND, 32'h8000_0001, '0, 1'b0, '0));
    send_command(make_command(OP_SEND, 32'h7FFF_FFFE, '0, 1'b0, '0));
    send_command(make_command(OP_SEND, 32'h0F0F_0F0F, '0, 1'b0, '0));
    send_command(make_command(OP_SEND, 32'hF0F0_F0F0, '0, 1'b0, '0));
    send_command(make_command(OP_SEND, 32'hCAFE_F00D, '0, 1'b0, '0));
    send_command(make_command(OP_TIMEOUT, '0, '0, 1'b0, 8'd4));
    send_command(make_command(OP_ACK, '0, 8'd7, 1'b1, '0));
    send_command(make_command(OP_SEND, 32'h0BAD_CAFE, '0, 1'b0, '0));
  endtask

  task automatic test_register_extremes();
    int win_vals[7] = '{0, 15, 8, 1, 15, 7, 4};
    int mod_vals[7] = '{0, 511, 256, 2, 3, 9, 8};
    for (int k = 0; k < 7; k++) begin
      settle_block();
      program_register(WINDOW_ADDR, CFG_DW'(win_vals[k]));
      program_register(MODULUS_ADDR, CFG_DW'(mod_vals[k]));
      // Fill one past the window so the replay covers its widest case.
      repeat (window_limit(seq_span()) + 1)
        send_command(make_command(OP_SEND, $urandom, '0, 1'b0, '0));
      send_command(make_command(OP_TIMEOUT, $urandom, '0, 1'b0,
                                SEQ_WIDTH'($urandom_range(0, 255))));
      send_command(random_command());
    end
  endtask

  task automatic test_random_traffic();
    idle_on = 1'b0;
    repeat (20) send_command(random_command());
    idle_on = 1'b1;
    repeat (5) send_command(random_command());
    settle_block();
    program_register(WINDOW_ADDR, CFG_DW'(6));
    program_register(MODULUS_ADDR, CFG_DW'(16));
    repeat (10) send_command(random_command());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_register(WINDOW_ADDR, CFG_DW'(WINDOW_RESET));
    test_directed_cases();
    test_register_extremes();
    test_random_traffic();
    settle_block();
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Each report is on the bus for one cycle only, so it is taken at the edge
  // that ends the strobe cycle.
  always @(posedge clk) begin : check_reports
    out_item_t want;
    string bad;
    if (rst_n && tx_strobe) begin
      if (report_wr == report_rd) begin
        report_mismatch($sformatf("result with nothing pending: %h", tx_report));
      end else begin
        want = sender_reports[report_rd % REPORT_DEPTH];
        report_rd++;
        bad = "";
        if (tx_report.status !== want.status) bad = {bad, " status"};
        if (tx_report.pkt_seq !== want.pkt_seq) bad = {bad, " pkt_seq"};
        if (tx_report.pkt_payload !== want.pkt_payload) bad = {bad, " pkt_payload"};
        if (tx_report.timer_stop !== want.timer_stop) bad = {bad, " timer_stop"};
        if (tx_report.timer_stop_seq !== want.timer_stop_seq) bad = {bad, " timer_stop_seq"};
        if (tx_report.timer_start !== want.timer_start) bad = {bad, " timer_start"};
        if (tx_report.timer_start_seq !== want.timer_start_seq)
          bad = {bad, " timer_start_seq"};
        if (tx_report.window_fill !== want.window_fill) bad = {bad, " window_fill"};
        if (tx_report.base_seq !== want.base_seq) bad = {bad, " base_seq"};
        if (tx_report.last !== want.last) bad = {bad, " last"};
        if (bad != "")
          report_mismatch($sformatf("wrong%s: got %h, want %h", bad, tx_report, want));
      end
    end
  end

endmodule

// ===== filelist.f =====
src/gbn_pkg.sv
src/gbn_ram.sv
src/gbn_ctrl.sv
src/gbn_dp.sv
src/go_back_n_sender_window.sv
src/gbn_chk.sv
bench/testbench.sv
